/* design/bmpnr_pkg.sv */
// ---------------------------------------------------------------------------
// bmpnr_pkg
// Shared types and constants for the binary mask pepper noise remover.
// ---------------------------------------------------------------------------
`default_nettype none

package bmpnr_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int STORE_ROWS        = 5;
   localparam int MARGIN            = 2;
   localparam logic [7:0]  SET_VALUE    = 8'd255;
   localparam logic [10:0] RESET_WIDTH  = 11'd640;
   localparam logic [15:0] RESET_HEIGHT = 16'd480;

   // register indexes on the control port
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // item kinds after classification
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] pixel;
   } item_type;

   typedef struct packed {
      logic [10:0] width;
      logic [15:0] height;
   } cfg_type;

endpackage

`default_nettype wire

/* design/binary_mask_pepper_noise_remover_top.sv */
// ---------------------------------------------------------------------------
// binary_mask_pepper_noise_remover_top: 5x5 pepper noise fill on a mask stream
// Output: accepted transfers pass the queue and execute; the output register
// loads once a pixel is final, three rows and three columns behind the input.
// Throughput: one item per cycle unless rsp stalls; execute is combinational.
// Reset: cursors, queue and window valid bits clear, registers go to 640x480.
// ---------------------------------------------------------------------------
`default_nettype none

module binary_mask_pepper_noise_remover_top
   import bmpnr_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] pixel_in
   input  wire logic        req_tuser,   // [0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] pixel_out
   output logic             rsp_tlast,   // frame_end
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type  cfg_ff, cfg_in;
   logic     cfg_we;
   logic     q_valid, q_pop;
   item_type q_item;

   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_we) begin
         if (csr_paddr[2] == REG_FRAME_WIDTH) begin
            cfg_in.width = csr_pwdata[10:0];
         end else begin
            cfg_in.height = csr_pwdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= RESET_WIDTH;
         cfg_ff.height <= RESET_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register reads
   always_comb begin
      case (csr_paddr[2])
         REG_FRAME_WIDTH:  csr_prdata = {21'd0, cfg_ff.width};
         REG_FRAME_HEIGHT: csr_prdata = {16'd0, cfg_ff.height};
         default:          csr_prdata = 32'd0;
      endcase
   end

   bmpnr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_func  (req_tuser),
      .in_pixel (req_tdata),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_item   (q_item)
   );

   bmpnr_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cfg_restart (cfg_we),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_pixel   (rsp_tdata),
      .out_last    (rsp_tlast)
   );

endmodule

`default_nettype wire

/* design/bmpnr_front.sv */
// ---------------------------------------------------------------------------
// bmpnr_front
// Accepts input transfers, classifies them and buffers them in a two-entry
// queue that decouples the input side from the execute side.
// ---------------------------------------------------------------------------
`default_nettype none

module bmpnr_front
   import bmpnr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire logic     in_func,
   input  wire logic [7:0] in_pixel,
   output logic          q_valid,
   input  wire logic     q_pop,
   output item_type      q_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   item_type   item_new;

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = entry_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;

   // classify the transfer
   always_comb begin
      item_new.op    = in_func ? OP_DRAIN : OP_PIXEL;
      item_new.pixel = in_pixel;
   end

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold queued items
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

`default_nettype wire

/* design/bmpnr_back.sv */
// ---------------------------------------------------------------------------
// bmpnr_back
// Executes queued items: stores pixels as column words of five rows, keeps a
// five-column window, edits the window when a centre qualifies, and emits
// finalized pixels through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bmpnr_back
   import bmpnr_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       cfg_restart,
   input  wire logic       q_valid,
   input  wire item_type   q_item,
   output logic            q_pop,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [7:0]      out_pixel,
   output logic            out_last
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = AW + 1;

   typedef logic [STORE_ROWS-1:0][7:0] colv_type;

   // (m - k) mod 5 for small m, k
   function automatic logic [2:0] slot_back(input logic [2:0] m, input logic [2:0] k);
      logic [3:0] t;
      t = {1'b0, m} + 4'd5 - {1'b0, k};
      if (t >= 4'd5) begin
         t = t - 4'd5;
      end
      return t[2:0];
   endfunction

   // cursors
   logic [15:0]   ir_ff, ir_in, cr_ff, cr_in, er_ff, er_in;
   logic [CW-1:0] ic_ff, ic_in, cc_ff, cc_in, ec_ff, ec_in;
   logic [2:0]    irm_ff, irm_in, erm_ff, erm_in;

   // window of the last five processed columns, slot 4 newest
   logic [AW-1:0] tag_ff [5];
   logic [AW-1:0] tag_in [5];
   colv_type      data_ff [5];
   colv_type      data_in [5];
   logic [4:0]    valid_ff, valid_in;

   // line store and its read registers
   colv_type      mem [MAX_WIDTH];
   colv_type      rd_in_ff, rd_em_ff;
   logic          we;
   logic [AW-1:0] waddr;
   colv_type      wdata;

   // output register
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_pixel_ff, out_pixel_in;
   logic          out_last_ff, out_last_in;

   logic [CW-1:0] w;
   logic [15:0]   h;
   logic          exec, store, visit, produce, last;
   logic          done_cur, done_new, received, final_px, centre_zero, ring;
   logic [CW:0]   cc_step;
   logic [2:0]    s_b2, s_b1, s_c, s_t1, s_t2;
   colv_type      v_load, v_emit;

   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;
   assign out_last  = out_last_ff;
   assign exec      = q_valid && (!out_valid_ff || out_ready);
   assign q_pop     = exec;

   // effective frame size
   always_comb begin
      if (cfg.width == 11'd0) begin
         w = CW'(1);
      end else if (32'(cfg.width) > MAX_WIDTH) begin
         w = CW'(MAX_WIDTH);
      end else begin
         w = CW'(cfg.width);
      end
      h = (cfg.height == 16'd0) ? 16'd1 : cfg.height;
   end

   // execute one item
   always_comb begin
      ir_in = ir_ff;  ic_in = ic_ff;  irm_in = irm_ff;
      cr_in = cr_ff;  cc_in = cc_ff;
      er_in = er_ff;  ec_in = ec_ff;  erm_in = erm_ff;
      tag_in   = tag_ff;
      data_in  = data_ff;
      valid_in = valid_ff;
      we = 1'b0;  waddr = tag_ff[0];  wdata = data_ff[0];
      visit = 1'b0;  centre_zero = 1'b0;  ring = 1'b0;
      cc_step = '0;
      v_load = rd_in_ff;
      s_b2 = irm_ff;
      s_b1 = slot_back(irm_ff, 3'd1);
      s_c  = slot_back(irm_ff, 3'd2);
      s_t1 = slot_back(irm_ff, 3'd3);
      s_t2 = slot_back(irm_ff, 3'd4);
      done_cur = (w < CW'(5)) || (h < 16'd5) || (cr_ff > h - 16'd3);
      store = exec && (q_item.op == OP_PIXEL) && (ir_ff < h);

      if (store) begin
         // take the newest copy of the column
         for (int k = 0; k < 5; k++) begin
            if (valid_ff[k] && tag_ff[k] == ic_ff[AW-1:0]) begin
               v_load = data_ff[k];
            end
         end
         v_load[irm_ff] = q_item.pixel;
         // evict the oldest column and shift the window
         we = valid_ff[0];
         for (int k = 0; k < 4; k++) begin
            tag_in[k]   = tag_ff[k+1];
            data_in[k]  = data_ff[k+1];
            valid_in[k] = valid_ff[k+1];
         end
         tag_in[4]   = ic_ff[AW-1:0];
         data_in[4]  = v_load;
         valid_in[4] = 1'b1;

         visit = !done_cur && ({1'b0, cr_ff} + 17'd2 == {1'b0, ir_ff}) &&
                 ({1'b0, cc_ff} + (CW+1)'(2) == {1'b0, ic_ff});
         if (visit) begin
            centre_zero = (data_in[2][s_c] == 8'd0);
            ring = 1'b1;
            for (int d = 0; d < 5; d++) begin
               ring = ring && (data_in[d][s_t2] != 8'd0) && (data_in[d][s_b2] != 8'd0);
            end
            ring = ring && (data_in[0][s_t1] != 8'd0) && (data_in[4][s_t1] != 8'd0) &&
                   (data_in[0][s_c] != 8'd0) && (data_in[4][s_c] != 8'd0) &&
                   (data_in[0][s_b1] != 8'd0) && (data_in[4][s_b1] != 8'd0);
            // fill the inner 3x3
            if (centre_zero && ring) begin
               for (int d = 1; d < 4; d++) begin
                  data_in[d][s_t1] = SET_VALUE;
                  data_in[d][s_c]  = SET_VALUE;
                  data_in[d][s_b1] = SET_VALUE;
               end
            end
            cc_step = {1'b0, cc_ff} + (centre_zero ? (CW+1)'(3) : (CW+1)'(1));
            if (cc_step > {1'b0, w} - (CW+1)'(3)) begin
               cc_in = CW'(MARGIN);
               cr_in = cr_ff + 16'd1;
            end else begin
               cc_in = cc_step[CW-1:0];
            end
         end

         // advance the input cursor
         if (ic_ff + CW'(1) >= w) begin
            ic_in  = '0;
            ir_in  = ir_ff + 16'd1;
            irm_in = (irm_ff == 3'd4) ? 3'd0 : irm_ff + 3'd1;
         end else begin
            ic_in = ic_ff + CW'(1);
         end
      end

      // decide whether the next pixel is final
      done_new = (w < CW'(5)) || (h < 16'd5) || (cr_in > h - 16'd3);
      received = (ir_in > er_ff) || ((ir_in == er_ff) && (ic_in > ec_ff));
      final_px = done_new || ({1'b0, cr_in} > {1'b0, er_ff} + 17'd1) ||
                 (({1'b0, cr_in} == {1'b0, er_ff} + 17'd1) &&
                  ({1'b0, cc_in} > {1'b0, ec_ff} + (CW+1)'(1)));
      produce = exec && received && final_px;
      last = (er_ff == h - 16'd1) && (ec_ff == w - CW'(1));

      // fetch the emitted pixel, newest copy first
      v_emit = rd_em_ff;
      if (we && waddr == ec_ff[AW-1:0]) begin
         v_emit = wdata;
      end
      for (int k = 0; k < 5; k++) begin
         if (valid_in[k] && tag_in[k] == ec_ff[AW-1:0]) begin
            v_emit = data_in[k];
         end
      end

      if (produce) begin
         if (last) begin
            ir_in = '0;  ic_in = '0;  irm_in = '0;
            cr_in = 16'(MARGIN);  cc_in = CW'(MARGIN);
            er_in = '0;  ec_in = '0;  erm_in = '0;
         end else if (ec_ff + CW'(1) >= w) begin
            ec_in  = '0;
            er_in  = er_ff + 16'd1;
            erm_in = (erm_ff == 3'd4) ? 3'd0 : erm_ff + 3'd1;
         end else begin
            ec_in = ec_ff + CW'(1);
         end
      end

      // restart the frame on a register write
      if (cfg_restart) begin
         ir_in = '0;  ic_in = '0;  irm_in = '0;
         cr_in = 16'(MARGIN);  cc_in = CW'(MARGIN);
         er_in = '0;  ec_in = '0;  erm_in = '0;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_pixel_in = out_pixel_ff;
      out_last_in  = out_last_ff;
      if (produce) begin
         out_valid_in = 1'b1;
         out_pixel_in = v_emit[erm_ff];
         out_last_in  = last;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ir_ff  <= '0;  ic_ff  <= '0;  irm_ff <= '0;
         cr_ff  <= 16'(MARGIN);  cc_ff <= CW'(MARGIN);
         er_ff  <= '0;  ec_ff  <= '0;  erm_ff <= '0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         ir_ff  <= ir_in;  ic_ff  <= ic_in;  irm_ff <= irm_in;
         cr_ff  <= cr_in;  cc_ff  <= cc_in;
         er_ff  <= er_in;  ec_ff  <= ec_in;  erm_ff <= erm_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold window and output payload
   always_ff @(posedge clock) begin
      tag_ff       <= tag_in;
      data_ff      <= data_in;
      out_pixel_ff <= out_pixel_in;
      out_last_ff  <= out_last_in;
   end

   // line store: one write, two prefetch reads with write forwarding
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (we && waddr == ic_in[AW-1:0]) begin
         rd_in_ff <= wdata;
      end else begin
         rd_in_ff <= mem[ic_in[AW-1:0]];
      end
      if (we && waddr == ec_in[AW-1:0]) begin
         rd_em_ff <= wdata;
      end else begin
         rd_em_ff <= mem[ec_in[AW-1:0]];
      end
   end

   a_emit_behind: assert property (@(posedge clock) disable iff (reset)
      er_ff <= ir_ff) else $error("emit row ahead of input row");

   a_visit_full: assert property (@(posedge clock) disable iff (reset)
      visit |-> (valid_in == 5'b11111)) else $error("centre visited with partial window");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (irm_ff < 3'd5) && (erm_ff < 3'd5)) else $error("row slot out of range");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (produce && last && !cfg_restart) |=> (er_ff == 16'd0 && ir_ff == 16'd0 &&
                                             cr_ff == 16'(MARGIN)))
      else $error("cursors not restarted after frame end");

endmodule

`default_nettype wire
